[rtl/puou_pkg.sv]
// ----------------------------------------------------------------------------
// puou_pkg: shared types and constants of the pixel unary op unit
// Mode codes, register indexes, CORDIC angle table and the controller states.
// ----------------------------------------------------------------------------
package puou_pkg;

    typedef enum logic [3:0] {
        MODE_ABS    = 4'd0,
        MODE_NEG    = 4'd1,
        MODE_INVERT = 4'd2,
        MODE_COPY   = 4'd3,
        MODE_GRAY   = 4'd4,
        MODE_SQUARE = 4'd5,
        MODE_SQRT   = 4'd6,
        MODE_ATAN   = 4'd7,
        MODE_COUNT  = 4'd8,
        MODE_PAD    = 4'd9
    } mode_t;

    localparam logic [2:0] REG_OP_MODE    = 3'd0;
    localparam logic [2:0] REG_FIELD_MIN  = 3'd1;
    localparam logic [2:0] REG_FIELD_MAX  = 3'd2;
    localparam logic [2:0] REG_SRC_WIDTH  = 3'd3;
    localparam logic [2:0] REG_SRC_HEIGHT = 3'd4;

    localparam int CNT_W = 26;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam int CORDIC_STEPS = 30;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RUN  = 4'b0010,
        ST_FIX  = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    // atan(2^-i) in Q2.30, rounded to nearest
    function automatic logic [31:0] atan_angle(input logic [4:0] i);
        logic [31:0] t;
        begin
            case (i)
                5'd0:    t = 32'd843314857;
                5'd1:    t = 32'd497837829;
                5'd2:    t = 32'd263043837;
                5'd3:    t = 32'd133525159;
                5'd4:    t = 32'd67021687;
                5'd5:    t = 32'd33543516;
                5'd6:    t = 32'd16775851;
                5'd7:    t = 32'd8388437;
                5'd8:    t = 32'd4194283;
                5'd9:    t = 32'd2097149;
                default: t = 32'd1 << (5'd30 - i);
            endcase
            atan_angle = t;
        end
    endfunction

endpackage

[rtl/pixel_unary_op_unit.sv]
// ----------------------------------------------------------------------------
// pixel_unary_op_unit: point operations on signed fixed-point samples
// Sequential unit with shift-register datapaths for the long operations.
// ----------------------------------------------------------------------------
// One sample at a time. Copy-like modes (abs, neg, invert, copy, count, pad)
// pass from input capture through the fixup state to the output. Square runs
// a bit-serial shift-add multiply of 32 steps, sqrt a restoring bit-pair root
// of 32 steps, gray a restoring divide by three of 34 steps, atan 30 CORDIC
// steps, each before the fixup state. The step loop sets the rate.
// The result waits in an output register; a new sample is taken once it is
// transferred.
module pixel_unary_op_unit #(
    parameter int MAX_DIM   = 4096,
    parameter int FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // sample_a[31:0], sample_b[63:32], sample_c[95:64], col_index[107:96],
    // row_index[119:108], zero fill [127:120]
    input  logic [127:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // result_value[31:0], nonzero_total[57:32], overflow_flag[58],
    // domain_error[59], zero fill [63:60]
    output logic [63:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    // CORDIC vector grows to about 1.65 times the scaled sample
    localparam int AW = 65 - FRAC_BITS;
    localparam logic [DIM_W-1:0] DIM_RST = DIM_W'(MAX_DIM);

    puou_pkg::state_t state_reg, state_next;
    logic [3:0]  mode_reg;
    logic signed [31:0] fmin_reg, fmax_reg;
    logic [DIM_W-1:0] srcw_reg, srch_reg;
    logic [puou_pkg::CNT_W-1:0] cnt_reg;

    // working registers
    logic [5:0]  step_reg;
    logic signed [31:0] a_reg;
    logic [11:0] col_reg, row_reg;
    logic [65:0] p_reg;       // multiplier / radicand / dividend shift
    logic [65:0] q_reg;       // product / root / quotient
    logic [65:0] r_reg;       // multiplicand shift / partial remainder
    logic signed [AW-1:0] x_reg, y_reg, z_reg;

    logic signed [31:0] res_reg;
    logic ovf_reg, dom_reg;

    wire in_fire = s_tvalid && s_tready;
    wire out_fire = m_tvalid && m_tready;
    assign s_tready = (state_reg == puou_pkg::ST_IDLE);
    assign m_tvalid = (state_reg == puou_pkg::ST_OUT);
    assign cfg_ready = 1'b1;
    assign m_tdata = {4'd0, dom_reg, ovf_reg, cnt_reg, res_reg};

    wire signed [31:0] in_a = s_tdata[31:0];
    wire signed [31:0] in_b = s_tdata[63:32];
    wire signed [31:0] in_c = s_tdata[95:64];
    wire [31:0] in_mag = in_a[31] ? 32'(-in_a) : in_a;

    logic [5:0] steps;
    always_comb
    begin
        case (mode_reg)
            puou_pkg::MODE_SQUARE: steps = 6'd32;
            puou_pkg::MODE_SQRT:   steps = 6'd32;
            puou_pkg::MODE_GRAY:   steps = 6'd34;
            puou_pkg::MODE_ATAN:   steps = 6'(puou_pkg::CORDIC_STEPS);
            default:               steps = 6'd0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            puou_pkg::ST_IDLE: if (in_fire) state_next = (steps == 6'd0) ?
                                   puou_pkg::ST_FIX : puou_pkg::ST_RUN;
            puou_pkg::ST_RUN:  if (step_reg == steps - 6'd1) state_next = puou_pkg::ST_FIX;
            puou_pkg::ST_FIX:  state_next = puou_pkg::ST_OUT;
            puou_pkg::ST_OUT:  if (out_fire) state_next = puou_pkg::ST_IDLE;
            default:           state_next = puou_pkg::ST_IDLE;
        endcase
    end

    // one step of each serial unit
    wire [65:0] prod_next = q_reg + (p_reg[0] ? {r_reg[65:0]} : 66'd0);
    wire [65:0] sq_rem = {r_reg[63:0], p_reg[65:64]};
    wire [65:0] sq_try = {q_reg[63:0], 2'b01};
    wire        sq_ok = (sq_rem >= sq_try);
    wire [65:0] dv_rem = {r_reg[64:0], p_reg[65]};
    wire        dv_ok = (dv_rem >= 66'd3);
    wire [4:0]  ci = step_reg[4:0];
    wire signed [AW-1:0] xs = x_reg >>> ci;
    wire signed [AW-1:0] ys = y_reg >>> ci;
    wire signed [AW-1:0] ang = AW'(puou_pkg::atan_angle(ci));

    // final fixups
    logic signed [33:0] wide;
    logic signed [31:0] fin;
    logic fin_ovf;
    always_comb
    begin
        wide = 34'sd0;
        fin = a_reg;
        fin_ovf = 1'b0;
        case (mode_reg)
            puou_pkg::MODE_ABS:
            begin
                wide = a_reg[31] ? -34'(a_reg) : 34'(a_reg);
                fin_ovf = (a_reg == 32'sh80000000);
                fin = fin_ovf ? 32'sh7fffffff : wide[31:0];
            end
            puou_pkg::MODE_NEG:
            begin
                fin_ovf = (a_reg == 32'sh80000000);
                fin = fin_ovf ? 32'sh7fffffff : -a_reg;
            end
            puou_pkg::MODE_INVERT:
            begin
                wide = 34'(fmax_reg) - 34'(a_reg) + 34'(fmin_reg);
                if (wide > 34'sh7fffffff)
                begin
                    fin_ovf = 1'b1;
                    fin = 32'sh7fffffff;
                end
                else if (wide < -34'sh80000000)
                begin
                    fin_ovf = 1'b1;
                    fin = 32'sh80000000;
                end
                else
                    fin = wide[31:0];
            end
            puou_pkg::MODE_GRAY:
            begin
                fin = a_reg[31] ? -32'(q_reg[33:0]) : 32'(q_reg[33:0]);
            end
            puou_pkg::MODE_SQUARE:
            begin
                fin_ovf = |(q_reg[63:0] >> (FRAC_BITS + 31));
                fin = fin_ovf ? 32'sh7fffffff : 32'(q_reg[63:0] >> FRAC_BITS);
            end
            puou_pkg::MODE_SQRT:
            begin
                fin = dom_reg ? 32'sd0 : q_reg[31:0];
            end
            puou_pkg::MODE_ATAN:
            begin
                fin = 32'((z_reg + (AW'(1) <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS));
            end
            puou_pkg::MODE_PAD:
            begin
                fin = ((DIM_W + 1)'(col_reg) < (DIM_W + 1)'(srcw_reg)
                    && (DIM_W + 1)'(row_reg) < (DIM_W + 1)'(srch_reg)) ? a_reg : 32'sd0;
            end
            default: fin = a_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= puou_pkg::ST_IDLE;
            mode_reg  <= puou_pkg::MODE_COPY;
            fmin_reg  <= '0;
            fmax_reg  <= '0;
            srcw_reg  <= DIM_RST;
            srch_reg  <= DIM_RST;
            cnt_reg   <= '0;
            step_reg  <= '0;
            ovf_reg   <= 1'b0;
            dom_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    puou_pkg::REG_OP_MODE:
                    begin
                        mode_reg <= cfg_data[3:0];
                        cnt_reg <= '0;
                    end
                    puou_pkg::REG_FIELD_MIN:  fmin_reg <= cfg_data;
                    puou_pkg::REG_FIELD_MAX:  fmax_reg <= cfg_data;
                    puou_pkg::REG_SRC_WIDTH:  srcw_reg <= DIM_W'(cfg_data[12:0]);
                    puou_pkg::REG_SRC_HEIGHT: srch_reg <= DIM_W'(cfg_data[12:0]);
                    default: ;
                endcase
            end
            if (in_fire)
            begin
                step_reg <= '0;
                dom_reg <= (mode_reg == puou_pkg::MODE_SQRT) && in_a[31];
                if (mode_reg == puou_pkg::MODE_COUNT && in_a != 32'sd0
                    && cnt_reg != puou_pkg::CNT_MAX)
                    cnt_reg <= cnt_reg + 1'b1;
            end
            else if (state_reg == puou_pkg::ST_RUN)
                step_reg <= step_reg + 6'd1;
            if (state_reg == puou_pkg::ST_FIX)
                ovf_reg <= fin_ovf;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            a_reg <= in_a;
            col_reg <= s_tdata[107:96];
            row_reg <= s_tdata[119:108];
            q_reg <= '0;
            r_reg <= '0;
            x_reg <= AW'(1) <<< 30;
            y_reg <= AW'(in_a) <<< (30 - FRAC_BITS);
            z_reg <= '0;
            case (mode_reg)
                puou_pkg::MODE_SQUARE:
                begin
                    p_reg <= 66'(in_mag);
                    r_reg <= 66'(in_mag);
                end
                // radicand in the top 64 bits walked by the 32 pair steps
                puou_pkg::MODE_SQRT: p_reg <= 66'(in_a) << (FRAC_BITS + 2);
                default:
                begin
                    // |a+b+c| left aligned for the divider
                    logic signed [33:0] s;
                    s = 34'(in_a) + 34'(in_b) + 34'(in_c);
                    p_reg <= {(s[33] ? -s : s), 32'd0};
                    a_reg <= (mode_reg == puou_pkg::MODE_GRAY) ? {s[33], 31'd0} : in_a;
                end
            endcase
        end
        else if (state_reg == puou_pkg::ST_RUN)
        begin
            case (mode_reg)
                puou_pkg::MODE_SQUARE:
                begin
                    q_reg <= prod_next;
                    p_reg <= p_reg >> 1;
                    r_reg <= r_reg << 1;
                end
                puou_pkg::MODE_SQRT:
                begin
                    p_reg <= p_reg << 2;
                    r_reg <= sq_ok ? sq_rem - sq_try : sq_rem;
                    q_reg <= {q_reg[64:0], sq_ok};
                end
                puou_pkg::MODE_GRAY:
                begin
                    p_reg <= p_reg << 1;
                    r_reg <= dv_ok ? dv_rem - 66'd3 : dv_rem;
                    q_reg <= {q_reg[64:0], dv_ok};
                end
                default:
                begin
                    if (y_reg > 0)
                    begin
                        x_reg <= x_reg + ys;
                        y_reg <= y_reg - xs;
                        z_reg <= z_reg + ang;
                    end
                    else
                    begin
                        x_reg <= x_reg - ys;
                        y_reg <= y_reg + xs;
                        z_reg <= z_reg - ang;
                    end
                end
            endcase
        end
        if (state_reg == puou_pkg::ST_FIX)
            res_reg <= fin;
    end

`ifndef SYNTHESIS
    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input taken while result pending");
    a_dom_sqrt: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[59] |-> m_tdata[31:0] == 32'd0)
        else $error("domain error with nonzero result");
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == puou_pkg::ST_RUN |-> step_reg < 6'd34)
        else $error("step counter overrun");
`endif

endmodule
